>>> hdl/tcfp_pkg.sv
// ----------------------------------------------------------------------------
// tcfp_pkg: shared types and constants of the threshold command frame parser
// Parse phases, register indexes, error bytes, range limits and reset values.
// ----------------------------------------------------------------------------
package tcfp_pkg;

  // Parse phases, one-hot
  typedef enum logic [3:0] {
    PH_HEAD  = 4'b0001,
    PH_CMD   = 4'b0010,
    PH_DATA  = 4'b0100,
    PH_CHECK = 4'b1000
  } phase_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_SYNC_BYTE  = 3'd0,
    REG_SET_CODE   = 3'd1,
    REG_ACK_CODE   = 3'd2,
    REG_ERROR_CODE = 3'd3,
    REG_TEMP_ID    = 3'd4,
    REG_HUMID_ID   = 3'd5,
    REG_LIGHT_ID   = 3'd6
  } reg_idx_t;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned REPLY_MAX = 6;
  localparam int unsigned REPLY_CNT_W = 3;

  // Reply lengths in bytes
  localparam logic [REPLY_CNT_W-1:0] ACK_LEN = 3'd6;
  localparam logic [REPLY_CNT_W-1:0] ERR_LEN = 3'd4;

  // Error bytes
  localparam logic [BYTE_W-1:0] ERR_RANGE = 8'd0;
  localparam logic [BYTE_W-1:0] ERR_PARAM = 8'd1;

  // Accepted value ranges
  localparam logic signed [15:0] TEMP_MIN   = -16'sd400;
  localparam logic signed [15:0] TEMP_MAX   = 16'sd850;
  localparam logic [15:0]        HUMID_MAX  = 16'd1000;
  localparam logic [15:0]        LIGHT_CEIL = 16'd4095;

  // Register reset values
  localparam logic [BYTE_W-1:0] SYNC_BYTE_RST  = 8'd170;
  localparam logic [BYTE_W-1:0] SET_CODE_RST   = 8'd1;
  localparam logic [BYTE_W-1:0] ACK_CODE_RST   = 8'd2;
  localparam logic [BYTE_W-1:0] ERROR_CODE_RST = 8'd3;
  localparam logic [BYTE_W-1:0] TEMP_ID_RST    = 8'd0;
  localparam logic [BYTE_W-1:0] HUMID_ID_RST   = 8'd1;
  localparam logic [BYTE_W-1:0] LIGHT_ID_RST   = 8'd2;

endpackage

>>> hdl/threshold_command_frame_parser_top.sv
// ----------------------------------------------------------------------------
// threshold_command_frame_parser_top: set-threshold request parser
// The first reply byte is valid in the cycle after the checksum byte is taken.
// Throughput: one received byte per cycle; a checksum byte waits only while
// reply bytes other than the one leaving this cycle are still queued in the
// 6-byte reply shift register.
// Reset (rst, synchronous): head search, registers to defaults, limits zero.
// ----------------------------------------------------------------------------
module threshold_command_frame_parser_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tcfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tcfp_pkg::BYTE_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    reply_byte,
  output logic                          reply_last,
  output logic signed [10:0]            temp_limit_now,
  output logic [9:0]                    humid_limit_now,
  output logic [11:0]                   light_limit_now
);
  import tcfp_pkg::*;

  // Configuration registers
  logic [7:0] sync_byte, set_code, ack_code, error_code;
  logic [7:0] temp_id, humid_id, light_id;

  // Parser state
  phase_t      phase, phase_next;
  logic [1:0]  byte_count;
  logic [7:0]  running_sum;
  logic [7:0]  payload_store [3];

  // Thresholds
  logic signed [10:0] temp_limit;
  logic [9:0]         humid_limit;
  logic [11:0]        light_limit;

  // Reply shift register, entry 0 is the byte on the output
  logic [7:0]             reply_buf [REPLY_MAX];
  logic [7:0]             reply_buf_next [REPLY_MAX];
  logic [REPLY_CNT_W-1:0] reply_cnt;

  logic in_req, out_req;
  logic frame_good;
  logic [15:0] value;
  logic signed [15:0] svalue;
  logic is_temp, is_humid, is_light;
  logic temp_ok, humid_ok, light_ok, value_ok;
  logic [7:0] err_byte;
  logic [7:0] ack_sum;

  // Checksum bytes wait until the previous reply has gone out or is leaving
  assign in_ready  = (phase != PH_CHECK) || (reply_cnt == '0) ||
                     ((reply_cnt == 3'd1) && out_ready);
  assign in_req    = in_valid && in_ready;
  assign out_valid = (reply_cnt != '0);
  assign out_req   = out_valid && out_ready;

  assign reply_byte      = reply_buf[0];
  assign reply_last      = (reply_cnt == 3'd1);
  assign temp_limit_now  = temp_limit;
  assign humid_limit_now = humid_limit;
  assign light_limit_now = light_limit;

  // Frame decode on the checksum byte
  assign frame_good = in_req && (phase == PH_CHECK) && (rx_byte == running_sum);
  assign value      = {payload_store[1], payload_store[2]};
  assign svalue     = $signed(value);
  assign is_temp    = (payload_store[0] == temp_id);
  assign is_humid   = !is_temp && (payload_store[0] == humid_id);
  assign is_light   = !is_temp && !is_humid && (payload_store[0] == light_id);
  assign temp_ok    = is_temp && (svalue >= TEMP_MIN) && (svalue <= TEMP_MAX);
  assign humid_ok   = is_humid && (value <= HUMID_MAX);
  assign light_ok   = is_light && (value <= LIGHT_CEIL);
  assign value_ok   = temp_ok || humid_ok || light_ok;
  assign err_byte   = (is_temp || is_humid || is_light) ? ERR_RANGE : ERR_PARAM;
  assign ack_sum    = ack_code + payload_store[0] + payload_store[1] + payload_store[2];

  // Next parse phase
  always_comb begin
    phase_next = phase;
    if (in_req) begin
      case (phase)
        PH_HEAD:  if (rx_byte == sync_byte) phase_next = PH_CMD;
        PH_CMD:   phase_next = (rx_byte == set_code) ? PH_DATA : PH_HEAD;
        PH_DATA:  if (byte_count == 2'd2) phase_next = PH_CHECK;
        PH_CHECK: phase_next = PH_HEAD;
        default:  phase_next = PH_HEAD;
      endcase
    end
  end

  // Next reply buffer: load a frame or shift one byte out
  always_comb begin
    for (int i = 0; i < REPLY_MAX; i++) reply_buf_next[i] = reply_buf[i];
    if (frame_good) begin
      reply_buf_next[0] = sync_byte;
      if (value_ok) begin
        reply_buf_next[1] = ack_code;
        reply_buf_next[2] = payload_store[0];
        reply_buf_next[3] = payload_store[1];
        reply_buf_next[4] = payload_store[2];
        reply_buf_next[5] = ack_sum;
      end else begin
        reply_buf_next[1] = error_code;
        reply_buf_next[2] = err_byte;
        reply_buf_next[3] = error_code + err_byte;
      end
    end else if (out_req) begin
      for (int i = 0; i < REPLY_MAX - 1; i++) reply_buf_next[i] = reply_buf[i+1];
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte  <= SYNC_BYTE_RST;
      set_code   <= SET_CODE_RST;
      ack_code   <= ACK_CODE_RST;
      error_code <= ERROR_CODE_RST;
      temp_id    <= TEMP_ID_RST;
      humid_id   <= HUMID_ID_RST;
      light_id   <= LIGHT_ID_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_SYNC_BYTE:  sync_byte  <= cfg_data;
        REG_SET_CODE:   set_code   <= cfg_data;
        REG_ACK_CODE:   ack_code   <= cfg_data;
        REG_ERROR_CODE: error_code <= cfg_data;
        REG_TEMP_ID:    temp_id    <= cfg_data;
        REG_HUMID_ID:   humid_id   <= cfg_data;
        REG_LIGHT_ID:   light_id   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Parser control and running checksum
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEAD;
      byte_count  <= '0;
      running_sum <= '0;
    end else begin
      phase <= phase_next;
      if (in_req) begin
        case (phase)
          PH_HEAD: begin
            if (rx_byte == sync_byte) begin
              running_sum <= '0;
              byte_count  <= '0;
            end
          end
          PH_CMD: begin
            if (rx_byte == set_code) begin
              running_sum <= rx_byte;
              byte_count  <= '0;
            end
          end
          PH_DATA: begin
            running_sum <= running_sum + rx_byte;
            byte_count  <= byte_count + 2'd1;
          end
          default: ;
        endcase
      end
    end
  end

  // Payload bytes, no reset
  always_ff @(posedge clk) begin
    if (in_req && (phase == PH_DATA)) begin
      case (byte_count)
        2'd0:    payload_store[0] <= rx_byte;
        2'd1:    payload_store[1] <= rx_byte;
        default: payload_store[2] <= rx_byte;
      endcase
    end
  end

  // Threshold updates
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_limit  <= '0;
      humid_limit <= '0;
      light_limit <= '0;
    end else if (frame_good) begin
      if (temp_ok)  temp_limit  <= svalue[10:0];
      if (humid_ok) humid_limit <= value[9:0];
      if (light_ok) light_limit <= value[11:0];
    end
  end

  // Reply shift register and byte count
  always_ff @(posedge clk) begin
    for (int i = 0; i < REPLY_MAX; i++) reply_buf[i] <= reply_buf_next[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reply_cnt <= '0;
    end else if (frame_good) begin
      reply_cnt <= value_ok ? ACK_LEN : ERR_LEN;
    end else if (out_req) begin
      reply_cnt <= reply_cnt - 3'd1;
    end
  end

endmodule

>>> tb/threshold_command_frame_parser_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// threshold_command_frame_parser_top_test: self-checking bench for the parser
// Feeds set-threshold request frames, broken frames and stray bytes, then
// checks every reply byte and the live limits against an in-bench model of
// the parser. Register settings change between phases, with both sides
// stalling at random.
// ----------------------------------------------------------------------------
module threshold_command_frame_parser_top_test;
  import tcfp_pkg::*;

  // Index past the last register; writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

  // Boundary values for the 16-bit request value
  localparam logic [15:0] EDGE_VALS [12] = '{
    16'hFE6F, 16'hFE70, 16'd850, 16'd851, 16'd1000, 16'd1001,
    16'd4095, 16'd4096, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000
  };

  typedef struct packed {
    logic [7:0]         data;
    logic               last;
    logic signed [10:0] temp;
    logic [9:0]         humid;
    logic [11:0]        light;
  } reply_t;

  // One directed frame: request bytes left-aligned, optional typed-in reply
  typedef struct packed {
    logic [47:0]        req;
    logic [2:0]         req_len;
    logic               typed;
    logic [47:0]        rep;
    logic [2:0]         rep_len;
    logic signed [10:0] t;
    logic [9:0]         h;
    logic [11:0]        l;
  } req_row_t;

  typedef struct packed {
    int unsigned seq;
    req_row_t    row;
  } typed_frame_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [BYTE_W-1:0]      cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [7:0]             rx_byte;
  logic                   out_valid;
  logic                   out_ready;
  logic [7:0]             reply_byte;
  logic                   reply_last;
  logic signed [10:0]     temp_limit_now;
  logic [9:0]             humid_limit_now;
  logic [11:0]            light_limit_now;

  threshold_command_frame_parser_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Parser model state and its copy of the registers
  phase_t             ph;
  logic [1:0]         n_taken;
  logic [7:0]         run_sum;
  logic [7:0]         held [3];
  logic [7:0]         cfg_copy [7];
  logic signed [10:0] temp_lim;
  logic [9:0]         humid_lim;
  logic [11:0]        light_lim;
  int unsigned        taken_n;

  reply_t       step_replies [$];
  reply_t       pending_replies [$];
  typed_frame_t typed_frames [$];

  // Stimulus side
  logic [7:0]  cfg_now [7];
  req_row_t    dir_tab [5];
  int unsigned sent_n;
  int unsigned errors;
  bit          calm;

  function automatic void log_fail(input string msg);
    errors++;
    if (errors <= 10) $display("%0t: %s", $time, msg);
  endfunction

  function automatic void add_reply(input logic [7:0] d, input logic last);
    step_replies.push_back(reply_t'{d, last, temp_lim, humid_lim, light_lim});
  endfunction

  // Good checksum: range-check, update the limit, build ACK or error frame
  function automatic void apply_threshold_request();
    logic [7:0]  id;
    logic [7:0]  err;
    logic [7:0]  sum;
    logic [15:0] val;
    bit          ok;
    id  = held[0];
    val = {held[1], held[2]};
    ok  = 1'b0;
    err = ERR_RANGE;
    // first matching id wins: temperature, humidity, light
    if (id == cfg_copy[REG_TEMP_ID]) begin
      if ($signed(val) >= TEMP_MIN && $signed(val) <= TEMP_MAX) begin
        temp_lim = val[10:0];
        ok = 1'b1;
      end
    end else if (id == cfg_copy[REG_HUMID_ID]) begin
      if (val <= HUMID_MAX) begin
        humid_lim = val[9:0];
        ok = 1'b1;
      end
    end else if (id == cfg_copy[REG_LIGHT_ID]) begin
      if (val <= LIGHT_CEIL) begin
        light_lim = val[11:0];
        ok = 1'b1;
      end
    end else begin
      err = ERR_PARAM;
    end
    add_reply(cfg_copy[REG_SYNC_BYTE], 1'b0);
    if (ok) begin
      sum = cfg_copy[REG_ACK_CODE] + held[0] + held[1] + held[2];
      add_reply(cfg_copy[REG_ACK_CODE], 1'b0);
      add_reply(held[0], 1'b0);
      add_reply(held[1], 1'b0);
      add_reply(held[2], 1'b0);
      add_reply(sum, 1'b1);
    end else begin
      sum = cfg_copy[REG_ERROR_CODE] + err;
      add_reply(cfg_copy[REG_ERROR_CODE], 1'b0);
      add_reply(err, 1'b0);
      add_reply(sum, 1'b1);
    end
  endfunction

  // One received byte through the frame parser
  function automatic void parse_rx_byte(input logic [7:0] b);
    case (ph)
      PH_HEAD: begin
        if (b == cfg_copy[REG_SYNC_BYTE]) begin
          ph      = PH_CMD;
          run_sum = 8'd0;
          n_taken = 2'd0;
        end
      end
      PH_CMD: begin
        if (b == cfg_copy[REG_SET_CODE]) begin
          run_sum = b;
          n_taken = 2'd0;
          ph      = PH_DATA;
        end else begin
          ph = PH_HEAD;
        end
      end
      PH_DATA: begin
        held[n_taken] = b;
        run_sum = run_sum + b;
        n_taken = n_taken + 2'd1;
        if (n_taken == 2'd3) ph = PH_CHECK;
      end
      default: begin
        if (b == run_sum) apply_threshold_request();
        ph = PH_HEAD;
      end
    endcase
  endfunction

  // Reply check, register shadow and prediction, all on the same edge
  always @(posedge clk) begin
    typed_frame_t frame;
    reply_t       got;
    reply_t       want;
    if (rst) begin
      ph        = PH_HEAD;
      n_taken   = 2'd0;
      run_sum   = 8'd0;
      held      = '{8'd0, 8'd0, 8'd0};
      temp_lim  = '0;
      humid_lim = '0;
      light_lim = '0;
      taken_n   = 0;
      cfg_copy[REG_SYNC_BYTE]  = SYNC_BYTE_RST;
      cfg_copy[REG_SET_CODE]   = SET_CODE_RST;
      cfg_copy[REG_ACK_CODE]   = ACK_CODE_RST;
      cfg_copy[REG_ERROR_CODE] = ERROR_CODE_RST;
      cfg_copy[REG_TEMP_ID]    = TEMP_ID_RST;
      cfg_copy[REG_HUMID_ID]   = HUMID_ID_RST;
      cfg_copy[REG_LIGHT_ID]   = LIGHT_ID_RST;
    end else begin
      if (out_valid && out_ready) begin
        got = reply_t'{reply_byte, reply_last, temp_limit_now, humid_limit_now,
                       light_limit_now};
        if (pending_replies.size() == 0) begin
          log_fail($sformatf("reply byte %h with nothing expected", reply_byte));
        end else begin
          want = pending_replies.pop_front();
          if (got !== want)
            log_fail($sformatf({"reply mismatch: byte %h/%h last %b/%b temp %0d/%0d",
                                " humid %0d/%0d light %0d/%0d (exp/got)"},
                               want.data, got.data, want.last, got.last,
                               want.temp, got.temp, want.humid, got.humid,
                               want.light, got.light));
        end
      end
      if (cfg_we && cfg_index <= REG_LIGHT_ID) cfg_copy[cfg_index] = cfg_data;
      if (in_valid && in_ready) begin
        step_replies.delete();
        parse_rx_byte(rx_byte);
        // directed rows with a typed-in reply take the place of the model's
        if (typed_frames.size() != 0 && typed_frames[0].seq == taken_n) begin
          frame = typed_frames.pop_front();
          for (int k = 0; k < frame.row.rep_len; k++)
            pending_replies.push_back(reply_t'{frame.row.rep[47 - 8*k -: 8],
                                               k == frame.row.rep_len - 1,
                                               frame.row.t, frame.row.h,
                                               frame.row.l});
        end else begin
          foreach (step_replies[k]) pending_replies.push_back(step_replies[k]);
        end
        taken_n++;
      end
    end
  end

  // Reply side back-pressure
  always @(posedge clk) out_ready <= calm || ($urandom_range(0, 99) >= 11);

  // One request byte, with an occasional gap before it
  task automatic send_byte(input logic [7:0] b);
    if (!calm && $urandom_range(0, 99) < 11) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    sent_n++;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and let every outstanding reply drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_replies.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // New register set: all zero, all ones, then random with shared ids
  task automatic load_settings(input int unsigned step);
    reg_idx_t   r;
    logic [7:0] v [7];
    wait_idle();
    r = REG_SYNC_BYTE;
    repeat (7) begin
      case (step)
        1:       v[r] = 8'h00;
        2:       v[r] = 8'hFF;
        default: v[r] = 8'($urandom_range(0, 255));
      endcase
      r = r.next();
    end
    if (step > 2 && $urandom_range(0, 1) == 0) v[REG_HUMID_ID] = v[REG_TEMP_ID];
    if (step > 2 && $urandom_range(0, 2) == 0) v[REG_LIGHT_ID] = v[REG_HUMID_ID];
    r = REG_SYNC_BYTE;
    repeat (7) begin
      set_reg(r, v[r]);
      cfg_now[r] = v[r];
      r = r.next();
    end
    set_reg(REG_NONE, 8'($urandom_range(0, 255)));
    cfg_we <= 1'b0;
  endtask

  // Random traffic: mostly set requests, some wrong commands and stray bytes
  task automatic send_sequence(output int unsigned counted);
    logic [7:0]  id;
    logic [7:0]  cmd;
    logic [7:0]  chk;
    logic [7:0]  b;
    logic [15:0] val;
    int unsigned roll;
    int unsigned n_stray;
    roll = $urandom_range(0, 99);
    if (roll < 75) begin
      case ($urandom_range(0, 4))
        0:       id = cfg_now[REG_TEMP_ID];
        1:       id = cfg_now[REG_HUMID_ID];
        2:       id = cfg_now[REG_LIGHT_ID];
        3:       id = 8'($urandom_range(0, 255));
        default: id = cfg_now[REG_SYNC_BYTE];
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3: val = EDGE_VALS[$urandom_range(0, 11)];
        4, 5:       val = 16'($urandom_range(0, 1000));
        6:          val = 16'(0 - $urandom_range(1, 400));
        default:    val = 16'($urandom_range(0, 65535));
      endcase
      chk = cfg_now[REG_SET_CODE] + id + val[15:8] + val[7:0];
      // bad checksum now and then
      if ($urandom_range(0, 9) == 0) chk = chk + 8'($urandom_range(1, 255));
      send_byte(cfg_now[REG_SYNC_BYTE]);
      send_byte(cfg_now[REG_SET_CODE]);
      send_byte(id);
      send_byte(val[15:8]);
      send_byte(val[7:0]);
      send_byte(chk);
      counted = 6;
    end else if (roll < 87) begin
      // wrong command, sometimes a repeated head
      cmd = $urandom_range(0, 1) ? cfg_now[REG_SYNC_BYTE] : 8'($urandom_range(0, 255));
      if (cmd == cfg_now[REG_SET_CODE]) cmd = cmd + 8'd1;
      send_byte(cfg_now[REG_SYNC_BYTE]);
      send_byte(cmd);
      counted = 2;
    end else begin
      // stray bytes between frames, never a head
      n_stray = $urandom_range(1, 3);
      repeat (n_stray) begin
        b = 8'($urandom_range(0, 255));
        if (b == cfg_now[REG_SYNC_BYTE]) b = b ^ 8'h01;
        send_byte(b);
      end
      counted = n_stray;
    end
  endtask

  initial begin
    req_row_t    row;
    int unsigned counted;
    int unsigned n_items;
    int unsigned next_cfg;
    int unsigned cfg_step;
    int unsigned guard;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = REG_SYNC_BYTE;
    cfg_data  = '0;
    in_valid  = 1'b0;
    rx_byte   = '0;
    out_ready = 1'b0;
    calm      = 1'b0;
    sent_n    = 0;
    errors    = 0;
    cfg_now[REG_SYNC_BYTE]  = SYNC_BYTE_RST;
    cfg_now[REG_SET_CODE]   = SET_CODE_RST;
    cfg_now[REG_ACK_CODE]   = ACK_CODE_RST;
    cfg_now[REG_ERROR_CODE] = ERROR_CODE_RST;
    cfg_now[REG_TEMP_ID]    = TEMP_ID_RST;
    cfg_now[REG_HUMID_ID]   = HUMID_ID_RST;
    cfg_now[REG_LIGHT_ID]   = LIGHT_ID_RST;

    // Directed frames at reset settings
    // temperature at its floor is accepted
    dir_tab[0] = '{{SYNC_BYTE_RST, SET_CODE_RST, TEMP_ID_RST, 16'hFE70, 8'h6F}, 3'd6,
                   1'b1, {SYNC_BYTE_RST, ACK_CODE_RST, TEMP_ID_RST, 16'hFE70, 8'h70},
                   3'd6, -11'sd400, 10'd0, 12'd0};
    // light at its ceiling is accepted
    dir_tab[1] = '{{SYNC_BYTE_RST, SET_CODE_RST, LIGHT_ID_RST, 16'h0FFF, 8'h11}, 3'd6,
                   1'b1, {SYNC_BYTE_RST, ACK_CODE_RST, LIGHT_ID_RST, 16'h0FFF, 8'h12},
                   3'd6, -11'sd400, 10'd0, 12'd4095};
    // humidity one past its ceiling: range error
    dir_tab[2] = '{{SYNC_BYTE_RST, SET_CODE_RST, HUMID_ID_RST, 16'h03E9, 8'hEE}, 3'd6,
                   1'b1, {SYNC_BYTE_RST, ERROR_CODE_RST, ERR_RANGE,
                          8'(ERROR_CODE_RST + ERR_RANGE), 16'h0000},
                   3'd4, -11'sd400, 10'd0, 12'd4095};
    // head byte as the parameter id: data, and an unknown parameter
    dir_tab[3] = '{{SYNC_BYTE_RST, SET_CODE_RST, SYNC_BYTE_RST, 16'h0000, 8'hAB}, 3'd6,
                   1'b1, {SYNC_BYTE_RST, ERROR_CODE_RST, ERR_PARAM,
                          8'(ERROR_CODE_RST + ERR_PARAM), 16'h0000},
                   3'd4, -11'sd400, 10'd0, 12'd4095};
    // wrong command byte, dropped
    dir_tab[4] = '{{SYNC_BYTE_RST, 8'h05, 32'h0}, 3'd2, 1'b0, 48'h0, 3'd0,
                   11'sd0, 10'd0, 12'd0};

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      if (row.typed) typed_frames.push_back(typed_frame_t'{sent_n + row.req_len - 1, row});
      for (int k = 0; k < row.req_len; k++) send_byte(row.req[47 - 8*k -: 8]);
    end

    // Random traffic, settings changed every few dozen request bytes
    n_items  = sent_n;
    next_cfg = 30;
    cfg_step = 0;
    while (n_items < 170) begin
      if (n_items >= next_cfg) begin
        cfg_step++;
        load_settings(cfg_step);
        next_cfg += 30;
      end
      calm = (n_items >= 60 && n_items < 110);
      send_sequence(counted);
      n_items += counted;
    end

    // Drain
    in_valid <= 1'b0;
    guard = 0;
    while (pending_replies.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    if (errors == 0 && pending_replies.size() == 0)
      $display("threshold_command_frame_parser_top_test: clean");
    else
      $display("threshold_command_frame_parser_top_test: errors");
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("threshold_command_frame_parser_top_test: errors");
    $finish;
  end

endmodule
